// ----- src/skt_pkg.sv -----
// Package for the sorted key table: widths, operation and status codes,
// cell commands and the neighbor word passed along the cell row.
// No dependencies.
package skt_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int ACT_W = 2;
  localparam int KEY_W = 20;
  localparam int HDL_W = 16;
  localparam int ST_W  = 3;
  localparam int OCC_W = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_FIND   = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE   = 2'd3
  } skt_action_e;

  typedef enum logic [ST_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_REMOVED   = 3'd5
  } skt_status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_CMP  = 2'd1,
    CELL_INS  = 2'd2,
    CELL_REM  = 2'd3
  } skt_cell_op_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [HDL_W-1:0] handle;
    logic             lt;
  } skt_nbr_t;

endpackage

// ----- src/skt_if.sv -----
// Request and response channel interfaces of the sorted key table.
// Depends on skt_pkg.
interface skt_req_if import skt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [KEY_W-1:0] key;
  logic [HDL_W-1:0] record_handle;

  modport source (output valid, action, key, record_handle, input ready);
  modport sink   (input valid, action, key, record_handle, output ready);
endinterface

interface skt_rsp_if import skt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [HDL_W-1:0] record_out;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, status, record_out, occupancy, input ready);
  modport sink   (input valid, status, record_out, occupancy, output ready);
endinterface

// ----- src/skt_cell.sv -----
// One cell of the table: holds a key and handle, compares against the
// broadcast key and shifts with its neighbors. Depends on skt_pkg.
module skt_cell import skt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  skt_cell_op_e     op_i,
  input  logic             valid_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [HDL_W-1:0] handle_i,
  input  skt_nbr_t         left_i,
  input  skt_nbr_t         right_i,
  output skt_nbr_t         self_o,
  output logic             eq_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic [HDL_W-1:0] hdl_q, hdl_d;
  logic             lt_q, lt_d, eq_q, eq_d;

  always_comb begin
    key_d = key_q;
    hdl_d = hdl_q;
    lt_d  = lt_q;
    eq_d  = eq_q;
    case (op_i)
      CELL_CMP: begin
        lt_d = valid_i && (key_q < key_i);
        eq_d = valid_i && (key_q == key_i);
      end
      CELL_INS: begin
        if (!lt_q) begin
          if (left_i.lt) begin
            key_d = key_i;
            hdl_d = handle_i;
          end else begin
            key_d = left_i.key;
            hdl_d = left_i.handle;
          end
        end
      end
      CELL_REM: begin
        if (!lt_q) begin
          key_d = right_i.key;
          hdl_d = right_i.handle;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    hdl_q <= hdl_d;
  end

  assign self_o.key    = key_q;
  assign self_o.handle = hdl_q;
  assign self_o.lt     = lt_q;
  assign eq_o          = eq_q;

endmodule

// ----- src/skt_chain.sv -----
// Row of CAPACITY cells with the match reduction over their flags.
// Depends on skt_pkg and skt_cell.
module skt_chain import skt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  skt_cell_op_e     op_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [HDL_W-1:0] handle_i,
  output logic             hit_o,
  output logic [HDL_W-1:0] handle_o
);

  skt_nbr_t   cell_w [CAPACITY];
  logic       eq_w   [CAPACITY];
  skt_nbr_t   head_w;

  assign head_w.key    = '0;
  assign head_w.handle = '0;
  assign head_w.lt     = 1'b1;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    skt_nbr_t left_w, right_w;
    if (i == 0) begin : g_head
      assign left_w = head_w;
    end else begin : g_mid
      assign left_w = cell_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_w = cell_w[i];
    end else begin : g_body
      assign right_w = cell_w[i+1];
    end

    skt_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .op_i     (op_i),
      .valid_i  (count_i > CNT_W'(i)),
      .key_i    (key_i),
      .handle_i (handle_i),
      .left_i   (left_w),
      .right_i  (right_w),
      .self_o   (cell_w[i]),
      .eq_o     (eq_w[i])
    );
  end

  always_comb begin
    hit_o    = 1'b0;
    handle_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_o    = hit_o | eq_w[i];
      handle_o = handle_o | (eq_w[i] ? cell_w[i].handle : '0);
    end
  end

endmodule

// ----- src/sorted_key_table.sv -----
// Sorted key table: up to CAPACITY unique keys with handles, ascending.
// A word is accepted in the idle state, compared by the row in the compare
// state and executed in the exec state, which waits while the previous
// response is unaccepted; a new word is taken only after the exec state.
// Reset clears the entry count, the cell flags and the response valid;
// entry contents are undefined until written.
module sorted_key_table import skt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  skt_req_if.sink   req_i,
  skt_rsp_if.source rsp_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [ACT_W-1:0] act_q;
  logic [KEY_W-1:0] key_q;
  logic [HDL_W-1:0] hdl_q;

  logic             ov_q, ov_d;
  logic [ST_W-1:0]  st_q, st_d;
  logic [HDL_W-1:0] rec_q, rec_d;
  logic [OCC_W-1:0] occ_q, occ_d;

  skt_cell_op_e     cell_op;
  logic             hit;
  logic [HDL_W-1:0] hit_hdl;
  logic             fire;
  logic             full;

  assign req_i.ready = (state_q == S_IDLE);
  assign fire        = (state_q == S_EXEC) && (!ov_q || rsp_o.ready);
  assign full        = (cnt_q == CNT_W'(CAPACITY));

  skt_chain u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (cell_op),
    .count_i  (cnt_q),
    .key_i    (key_q),
    .handle_i (hdl_q),
    .hit_o    (hit),
    .handle_o (hit_hdl)
  );

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cell_op = CELL_HOLD;
    st_d    = st_q;
    rec_d   = rec_q;
    occ_d   = occ_q;
    ov_d    = ov_q && !rsp_o.ready;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) state_d = S_CMP;
      end
      S_CMP: begin
        cell_op = CELL_CMP;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (fire) begin
          st_d  = ST_NOT_FOUND;
          rec_d = '0;
          case (act_q)
            ACT_INSERT: begin
              if (hit) begin
                st_d = ST_DUPLICATE;
              end else if (full) begin
                st_d = ST_FULL;
              end else begin
                st_d    = ST_INSERTED;
                cell_op = CELL_INS;
                cnt_d   = cnt_q + CNT_W'(1);
              end
            end
            ACT_FIND: begin
              if (hit) begin
                st_d  = ST_FOUND;
                rec_d = hit_hdl;
              end
            end
            ACT_REMOVE: begin
              if (hit) begin
                st_d    = ST_REMOVED;
                rec_d   = hit_hdl;
                cell_op = CELL_REM;
                cnt_d   = cnt_q - CNT_W'(1);
              end
            end
            default: ;
          endcase
          occ_d   = OCC_W'(cnt_d);
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      act_q <= req_i.action;
      key_q <= req_i.key;
      hdl_q <= req_i.record_handle;
    end
    st_q  <= st_d;
    rec_q <= rec_d;
    occ_q <= occ_d;
  end

  assign rsp_o.valid      = ov_q;
  assign rsp_o.status     = st_q;
  assign rsp_o.record_out = rec_q;
  assign rsp_o.occupancy  = occ_q;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for sorted_key_table: directed and random insert, find and remove words,
// checked against a shadow copy of the sorted table kept in a scoreboard class.
// Depends on skt_pkg, skt_if and the sorted_key_table RTL.
module testbench;
  import skt_pkg::*;

  localparam int N_RANDOM     = 950;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int POOL_SIZE    = 24;

  typedef struct {
    logic [ST_W-1:0]  status;
    logic [HDL_W-1:0] record_out;
    logic [OCC_W-1:0] occupancy;
  } table_reply_t;

  class table_shadow;
    logic [KEY_W-1:0] slot_key[CAPACITY];
    logic [HDL_W-1:0] slot_handle[CAPACITY];
    int unsigned      fill_count;
    table_reply_t     pending_replies[$];
    int               error_count;
    int               request_count;
    int               status_seen[6];

    function new();
      fill_count    = 0;
      error_count   = 0;
      request_count = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void note_request(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k,
                               logic [HDL_W-1:0] h);
      table_reply_t r;
      int unsigned  pos;
      bit           hit;
      pos = 0;
      while (pos < fill_count && slot_key[pos] < k) pos++;
      hit          = (pos < fill_count) && (slot_key[pos] == k);
      r.status     = ST_NOT_FOUND;
      r.record_out = '0;
      if (act == ACT_INSERT) begin
        if (hit) begin
          r.status = ST_DUPLICATE;
        end else if (fill_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int j = fill_count; j > pos; j--) begin
            slot_key[j]    = slot_key[j-1];
            slot_handle[j] = slot_handle[j-1];
          end
          slot_key[pos]    = k;
          slot_handle[pos] = h;
          fill_count++;
          r.status = ST_INSERTED;
        end
      end else if (act == ACT_FIND) begin
        if (hit) begin
          r.status     = ST_FOUND;
          r.record_out = slot_handle[pos];
        end
      end else if (act == ACT_REMOVE) begin
        if (hit) begin
          r.record_out = slot_handle[pos];
          for (int j = pos; j + 1 < fill_count; j++) begin
            slot_key[j]    = slot_key[j+1];
            slot_handle[j] = slot_handle[j+1];
          end
          fill_count--;
          r.status = ST_REMOVED;
        end
      end
      r.occupancy = OCC_W'(fill_count);
      pending_replies.push_back(r);
      request_count++;
    endfunction

    function void check_reply(logic [ST_W-1:0] st, logic [HDL_W-1:0] rec,
                              logic [OCC_W-1:0] occ);
      table_reply_t e;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected word status %0d record %0h occupancy %0d",
                 $time, st, rec, occ);
        error_count++;
        return;
      end
      e = pending_replies.pop_front();
      status_seen[int'(e.status)]++;
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        error_count++;
      end
      if (rec !== e.record_out) begin
        $display("%0t: record_out expected %0h actual %0h", $time, e.record_out, rec);
        error_count++;
      end
      if (occ !== e.occupancy) begin
        $display("%0t: occupancy expected %0d actual %0d", $time, e.occupancy, occ);
        error_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  int   burst_left  = 0;
  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  table_shadow shadow = new();

  skt_req_if req ();
  skt_rsp_if rsp ();

  sorted_key_table dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time,
               shadow.pending_replies.size());
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp.valid && rsp.ready) begin
      shadow.check_reply(rsp.status, rsp.record_out, rsp.occupancy);
    end
  end

  initial begin
    int hold;
    int sel;
    rsp.ready = 1'b0;
    hold      = 0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
          rsp.ready <= 1'b1;
          hold = $urandom_range(0, 24);
        end else if (sel < 8) begin
          rsp.ready <= 1'b0;
          hold = $urandom_range(0, 2);
        end else begin
          rsp.ready <= 1'b0;
          hold = $urandom_range(3, 14);
        end
      end else begin
        hold--;
      end
    end
  end

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      req.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 12);
    end
  endtask

  task automatic send_word(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] k,
                           input logic [HDL_W-1:0] h);
    @(negedge clk);
    req.valid         <= 1'b1;
    req.action        <= act;
    req.key           <= k;
    req.record_handle <= h;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    shadow.note_request(act, k, h);
    pace_sender();
  endtask

  task automatic refill_pool();
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = KEY_W'(999999);
    key_pool[3] = KEY_W'(1000000);
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(bit from_table);
    if (from_table && shadow.fill_count > 0) begin
      return shadow.slot_key[$urandom_range(0, shadow.fill_count - 1)];
    end
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return KEY_W'($urandom);
  endfunction

  function automatic logic [HDL_W-1:0] pick_handle();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return HDL_W'($urandom);
  endfunction

  task automatic run_directed();
    send_word(ACT_INSERT, KEY_W'(500000), 16'hffff);
    send_word(ACT_INSERT, '0, 16'h0000);
    send_word(ACT_INSERT, '1, 16'h1234);
    send_word(ACT_INSERT, KEY_W'(999999), 16'haaaa);
    send_word(ACT_INSERT, KEY_W'(500000), 16'h5555);
    send_word(ACT_FIND, '0, 16'hffff);
    send_word(ACT_FIND, '1, 16'h0000);
    send_word(ACT_FIND, KEY_W'(12345), 16'h0000);
    send_word(ACT_NONE, '0, 16'hffff);
    // fill to capacity with keys spread between the existing ones
    for (int i = 1; i <= 12; i++) begin
      send_word(ACT_INSERT, KEY_W'(i * 70001 + 3), HDL_W'(i * 5003));
    end
    send_word(ACT_INSERT, KEY_W'(999999), 16'h0001);
    send_word(ACT_INSERT, KEY_W'(777), 16'h0002);
    send_word(ACT_REMOVE, KEY_W'(500000), 16'h0000);
    send_word(ACT_REMOVE, KEY_W'(500000), 16'hffff);
    send_word(ACT_REMOVE, '0, 16'h0000);
    send_word(ACT_REMOVE, '1, 16'h0000);
  endtask

  task automatic run_random();
    int mode;
    int roll;
    int ins_lim;
    int find_lim;
    logic [ACT_W-1:0] act;
    logic [KEY_W-1:0] k;
    mode = 2;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 200 == 0) refill_pool();
      if (i % 60 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: begin
          ins_lim  = 70;
          find_lim = 85;
        end
        1: begin
          ins_lim  = 15;
          find_lim = 35;
        end
        default: begin
          ins_lim  = 35;
          find_lim = 65;
        end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < ins_lim) act = ACT_INSERT;
      else if (roll < find_lim) act = ACT_FIND;
      else if (roll < 95) act = ACT_REMOVE;
      else act = ACT_NONE;
      if (act == ACT_INSERT) k = pick_key(1'b0);
      else k = pick_key($urandom_range(0, 3) != 0);
      send_word(act, k, pick_handle());
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    req.valid         = 1'b0;
    req.action        = ACT_INSERT;
    req.key           = '0;
    req.record_handle = '0;
    refill_pool();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    @(negedge clk);
    req.valid <= 1'b0;
    while (shadow.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.pending_replies.size() != 0) begin
      $display("%0t: %0d words never answered", $time, shadow.pending_replies.size());
      shadow.error_count++;
    end
    $display("covered %0d requests in %0d cycles with random sender gaps and stalls",
             shadow.request_count, cycle_count);
    $display("inserted %0d duplicate %0d full %0d found %0d not found %0d removed %0d",
             shadow.status_seen[ST_INSERTED], shadow.status_seen[ST_DUPLICATE],
             shadow.status_seen[ST_FULL], shadow.status_seen[ST_FOUND],
             shadow.status_seen[ST_NOT_FOUND], shadow.status_seen[ST_REMOVED]);
    if (shadow.error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/skt_pkg.sv
src/skt_if.sv
src/skt_cell.sv
src/skt_chain.sv
src/sorted_key_table.sv
sim/testbench.sv
